// ===== design/utx_pkg.sv =====
// ----------------------------------------------------------------------------
// utx_pkg: shared types and constants for the UART transmitter
// Frame phases, register indexes, effective configuration and queue entries.
// ----------------------------------------------------------------------------
package utx_pkg;

   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;
   localparam int BIT_PERIOD_W  = 20;
   localparam int DATA_BITS_W   = 4;
   localparam int BYTE_W        = 8;

   // register indexes (byte address is 4 * index)
   localparam logic [2:0] REG_BIT_PERIOD   = 3'd0;
   localparam logic [2:0] REG_DATA_BITS    = 3'd1;
   localparam logic [2:0] REG_PARITY_MODE  = 3'd2;
   localparam logic [2:0] REG_STOP_BITS    = 3'd3;
   localparam logic [2:0] REG_INVERT_LINE  = 3'd4;
   localparam logic [2:0] REG_DRIVE_ENABLE = 3'd5;

   // reset values
   localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RESET = 20'd8333;
   localparam logic [DATA_BITS_W-1:0]  DATA_BITS_RESET  = 4'd8;
   localparam logic [DATA_BITS_W-1:0]  DATA_BITS_MIN    = 4'd5;
   localparam logic [DATA_BITS_W-1:0]  DATA_BITS_MAX    = 4'd8;
   localparam logic [1:0]              STOP_BITS_RESET  = 2'd1;

   // parity mode codes
   localparam logic [1:0] PARITY_NONE = 2'd0;
   localparam logic [1:0] PARITY_EVEN = 2'd1;
   localparam logic [1:0] PARITY_ODD  = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_DATA,
      PH_PARITY,
      PH_STOP
   } phase_type;

   typedef enum logic {
      ITEM_TICK,
      ITEM_SEND
   } item_kind_type;

   typedef struct packed {
      item_kind_type     kind;
      logic [BYTE_W-1:0] send_byte;
   } queue_entry_type;

   // configuration with out-of-range codes already folded to their meaning
   typedef struct packed {
      logic [BIT_PERIOD_W-1:0] period;
      logic [DATA_BITS_W-1:0]  data_bits;
      logic                    parity_on;
      logic                    parity_odd;
      logic                    two_stop;
      logic                    invert;
      logic                    drive_enable;
   } cfg_type;

endpackage

// ===== design/utx_channels.sv =====
// ----------------------------------------------------------------------------
// utx_channels: valid/ready channels of the UART transmitter
// Request channel carries one clock tick of input, response one tick of output.
// ----------------------------------------------------------------------------
interface utx_req_if;
   logic       valid;
   logic       ready;
   logic       send_request;
   logic [7:0] send_byte;

   modport source (output valid, output send_request, output send_byte, input ready);
   modport sink   (input valid, input send_request, input send_byte, output ready);
endinterface

interface utx_rsp_if;
   logic valid;
   logic ready;
   logic line_level;
   logic driver_enable;
   logic busy_res;
   logic accepted;

   modport source (output valid, output line_level, output driver_enable,
                   output busy_res, output accepted, input ready);
   modport sink   (input valid, input line_level, input driver_enable,
                   input busy_res, input accepted, output ready);
endinterface

// ===== design/utx_csr.sv =====
// ----------------------------------------------------------------------------
// utx_csr: APB register file of the UART transmitter
// Holds the six configuration registers and folds them into effective values.
// ----------------------------------------------------------------------------
module utx_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [utx_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [utx_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [utx_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output utx_pkg::cfg_type                 cfg
);
   import utx_pkg::*;

   logic [BIT_PERIOD_W-1:0] bit_period_ff, bit_period_in;
   logic [DATA_BITS_W-1:0]  data_bits_ff, data_bits_in;
   logic [1:0]              parity_mode_ff, parity_mode_in;
   logic [1:0]              stop_bits_ff, stop_bits_in;
   logic                    invert_ff, invert_in;
   logic                    drive_en_ff, drive_en_in;
   logic                    wr_en;
   logic [2:0]              reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite;
   assign reg_index = paddr[4:2];

   always_comb begin
      bit_period_in  = bit_period_ff;
      data_bits_in   = data_bits_ff;
      parity_mode_in = parity_mode_ff;
      stop_bits_in   = stop_bits_ff;
      invert_in      = invert_ff;
      drive_en_in    = drive_en_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_BIT_PERIOD:   bit_period_in  = pwdata[BIT_PERIOD_W-1:0];
            REG_DATA_BITS:    data_bits_in   = pwdata[DATA_BITS_W-1:0];
            REG_PARITY_MODE:  parity_mode_in = pwdata[1:0];
            REG_STOP_BITS:    stop_bits_in   = pwdata[1:0];
            REG_INVERT_LINE:  invert_in      = pwdata[0];
            REG_DRIVE_ENABLE: drive_en_in    = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff  <= BIT_PERIOD_RESET;
         data_bits_ff   <= DATA_BITS_RESET;
         parity_mode_ff <= PARITY_NONE;
         stop_bits_ff   <= STOP_BITS_RESET;
         invert_ff      <= 1'b0;
         drive_en_ff    <= 1'b0;
      end else begin
         bit_period_ff  <= bit_period_in;
         data_bits_ff   <= data_bits_in;
         parity_mode_ff <= parity_mode_in;
         stop_bits_ff   <= stop_bits_in;
         invert_ff      <= invert_in;
         drive_en_ff    <= drive_en_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_BIT_PERIOD:   prdata = CSR_DATA_W'(bit_period_ff);
         REG_DATA_BITS:    prdata = CSR_DATA_W'(data_bits_ff);
         REG_PARITY_MODE:  prdata = CSR_DATA_W'(parity_mode_ff);
         REG_STOP_BITS:    prdata = CSR_DATA_W'(stop_bits_ff);
         REG_INVERT_LINE:  prdata = CSR_DATA_W'(invert_ff);
         REG_DRIVE_ENABLE: prdata = CSR_DATA_W'(drive_en_ff);
         default:          prdata = '0;
      endcase
   end

   // zero period runs as one tick, bad data widths as eight, parity code 3 as none
   always_comb begin
      cfg.period       = (bit_period_ff == '0) ? BIT_PERIOD_W'(1) : bit_period_ff;
      cfg.data_bits    = (data_bits_ff >= DATA_BITS_MIN && data_bits_ff <= DATA_BITS_MAX)
                         ? data_bits_ff : DATA_BITS_MAX;
      cfg.parity_on    = (parity_mode_ff == PARITY_EVEN) || (parity_mode_ff == PARITY_ODD);
      cfg.parity_odd   = (parity_mode_ff == PARITY_ODD);
      cfg.two_stop     = stop_bits_ff[1];
      cfg.invert       = invert_ff;
      cfg.drive_enable = drive_en_ff;
   end

endmodule

// ===== design/utx_front.sv =====
// ----------------------------------------------------------------------------
// utx_front: input stage of the UART transmitter
// Registers each request transfer and tags it as a plain tick or a send.
// ----------------------------------------------------------------------------
module utx_front (
   input  logic                     clock,
   input  logic                     reset,
   utx_req_if.sink                  req_if,
   output logic                     push_valid,
   output utx_pkg::queue_entry_type push_entry,
   input  logic                     push_ready
);
   import utx_pkg::*;

   logic            front_valid_ff, front_valid_in;
   queue_entry_type entry_ff;
   logic            take;

   assign req_if.ready = ~front_valid_ff | push_ready;
   assign take         = req_if.valid & req_if.ready;
   assign push_valid   = front_valid_ff;
   assign push_entry   = entry_ff;

   always_comb begin
      front_valid_in = front_valid_ff;
      if (take) begin
         front_valid_in = 1'b1;
      end else if (push_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         entry_ff.kind      <= req_if.send_request ? ITEM_SEND : ITEM_TICK;
         entry_ff.send_byte <= req_if.send_byte;
      end
   end

endmodule

// ===== design/utx_fifo.sv =====
// ----------------------------------------------------------------------------
// utx_fifo: short queue between the front and back of the UART transmitter
// Circular buffer of register slots; full is taken from the count alone.
// ----------------------------------------------------------------------------
module utx_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  utx_pkg::queue_entry_type push_entry,
   output logic                     push_ready,
   output logic                     pop_valid,
   output utx_pkg::queue_entry_type pop_entry,
   input  logic                     pop
);
   import utx_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== design/utx_back.sv =====
// ----------------------------------------------------------------------------
// utx_back: frame engine of the UART transmitter
// Runs one clock tick of bit timing per queued item and registers the result.
// ----------------------------------------------------------------------------
module utx_back (
   input  logic                     clock,
   input  logic                     reset,
   input  utx_pkg::cfg_type         cfg,
   input  logic                     pop_valid,
   input  utx_pkg::queue_entry_type pop_entry,
   output logic                     pop,
   utx_rsp_if.source                rsp_if
);
   import utx_pkg::*;

   phase_type               phase_ff, phase_in, phase_cur;
   logic [BIT_PERIOD_W-1:0] tick_ff, tick_in, tick_cur, tick_next;
   logic [2:0]              bit_idx_ff, bit_idx_in, bit_idx_cur;
   logic [BYTE_W-1:0]       shift_ff, shift_in, shift_cur;
   logic                    parity_ff, parity_in, parity_cur;
   logic                    stop_idx_ff, stop_idx_in, stop_idx_cur;

   logic rsp_valid_ff, rsp_valid_in;
   logic line_ff, drv_en_ff, busy_ff, acc_ff;

   logic advance, start, busy, level, bit_end;

   assign advance = pop_valid & (~rsp_valid_ff | rsp_if.ready);
   assign pop     = advance;

   // a send taken while idle starts the frame on this very tick
   assign start        = (phase_ff == PH_IDLE) && (pop_entry.kind == ITEM_SEND);
   assign phase_cur    = start ? PH_START : phase_ff;
   assign tick_cur     = start ? '0 : tick_ff;
   assign bit_idx_cur  = start ? '0 : bit_idx_ff;
   assign shift_cur    = start ? pop_entry.send_byte : shift_ff;
   assign parity_cur   = start ? 1'b0 : parity_ff;
   assign stop_idx_cur = start ? 1'b0 : stop_idx_ff;
   assign busy         = (phase_cur != PH_IDLE);
   assign tick_next    = tick_cur + 1'b1;
   assign bit_end      = (tick_next >= cfg.period) || (tick_next == '0);

   always_comb begin
      unique case (phase_cur)
         PH_START:  level = 1'b0;
         PH_DATA:   level = shift_cur[0];
         PH_PARITY: level = parity_cur ^ cfg.parity_odd;
         default:   level = 1'b1;
      endcase
   end

   always_comb begin
      phase_in    = phase_cur;
      tick_in     = tick_cur;
      bit_idx_in  = bit_idx_cur;
      shift_in    = shift_cur;
      parity_in   = parity_cur;
      stop_idx_in = stop_idx_cur;
      if (busy) begin
         tick_in = bit_end ? '0 : tick_next;
         if (bit_end) begin
            unique case (phase_cur)
               PH_START: begin
                  phase_in   = PH_DATA;
                  bit_idx_in = '0;
               end
               PH_DATA: begin
                  parity_in = parity_cur ^ shift_cur[0];
                  shift_in  = {1'b0, shift_cur[BYTE_W-1:1]};
                  if ({1'b0, bit_idx_cur} + 4'd1 >= cfg.data_bits) begin
                     bit_idx_in  = '0;
                     stop_idx_in = 1'b0;
                     phase_in    = cfg.parity_on ? PH_PARITY : PH_STOP;
                  end else begin
                     bit_idx_in = bit_idx_cur + 1'b1;
                  end
               end
               PH_PARITY: begin
                  phase_in    = PH_STOP;
                  stop_idx_in = 1'b0;
               end
               PH_STOP: begin
                  if (!cfg.two_stop || stop_idx_cur) begin
                     phase_in    = PH_IDLE;
                     stop_idx_in = 1'b0;
                  end else begin
                     stop_idx_in = 1'b1;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tick_ff     <= '0;
         bit_idx_ff  <= '0;
         shift_ff    <= '0;
         parity_ff   <= 1'b0;
         stop_idx_ff <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         bit_idx_ff  <= bit_idx_in;
         shift_ff    <= shift_in;
         parity_ff   <= parity_in;
         stop_idx_ff <= stop_idx_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         line_ff   <= level ^ cfg.invert;
         drv_en_ff <= busy & cfg.drive_enable;
         busy_ff   <= busy;
         acc_ff    <= start;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.line_level    = line_ff;
   assign rsp_if.driver_enable = drv_en_ff;
   assign rsp_if.busy_res      = busy_ff;
   assign rsp_if.accepted      = acc_ff;

endmodule

// ===== design/uart_transmitter.sv =====
// ----------------------------------------------------------------------------
// uart_transmitter: asynchronous serial transmitter, one transfer per tick
// Each request transfer stands for one clock tick of bit timing: it may ask
// to send a byte, and it yields exactly one response transfer with the line
// level, driver enable, busy flag and accepted flag of that tick. A frame is
// a start bit, 5 to 8 data bits LSB first, optional parity and 1 or 2 stop
// bits, each held for bit_period ticks; requests made while busy are dropped.
// Configuration is written over the APB port (register i at byte 4*i). The
// user writes it only while no transfers are in flight; the block itself
// does not enforce this. Each response leaves the output register after
// its request transfer has passed the input register and the queue.
// Throughput: one transfer per cycle unless the response side stalls, set
// by the frame engine: one 20-bit tick increment and compare per transfer.
// Reset: registers return to their defaults, the frame engine goes idle and
// the queue empties; no clearing pass is needed.
// Stall: while the response side is stalled the output register holds its
// transfer, the queue fills, and then the request side sees ready drop.
// ----------------------------------------------------------------------------
module uart_transmitter #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   utx_req_if.sink                        req_if,
   utx_rsp_if.source                      rsp_if,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [utx_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [utx_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [utx_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import utx_pkg::*;

   cfg_type         cfg;
   logic            push_valid, push_ready;
   queue_entry_type push_entry;
   logic            pop_valid, pop;
   queue_entry_type pop_entry;

   // register file: raw registers, folded into effective settings
   utx_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // front: take each request transfer and tag it
   utx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // queue: decouple request stalls from response stalls
   utx_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   // back: advance the frame one tick per item, hold the result until taken
   utx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== design/utx_checker.sv =====
// ----------------------------------------------------------------------------
// utx_checker: port-level checks for the UART transmitter
// Watches the response channel and is bound to the top level.
// ----------------------------------------------------------------------------
module utx_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic line_level,
   input logic driver_enable,
   input logic busy_res,
   input logic accepted
);

   // no response survives a reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // driver enable only within a frame
   a_drv_in_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && driver_enable) |-> busy_res)
      else $error("driver enable outside a frame");

   // a taken request opens a frame on the same tick
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && accepted) |-> busy_res)
      else $error("accepted without busy");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable({line_level, driver_enable, busy_res, accepted})))
      else $error("stalled response changed");

endmodule

bind uart_transmitter utx_checker u_utx_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .line_level    (rsp_if.line_level),
   .driver_enable (rsp_if.driver_enable),
   .busy_res      (rsp_if.busy_res),
   .accepted      (rsp_if.accepted)
);

// ===== bench/uart_transmitter_test.sv =====
// ----------------------------------------------------------------------------
// uart_transmitter_test: self-checking bench for the UART transmitter
// Every request transfer is one tick of bit timing. A tick-accurate frame
// predictor runs beside the block, and each response transfer is checked
// field by field against it. A short scripted opening covers reset, dropped
// requests, back-to-back frames, folded register codes and mid-frame register
// changes. Random phases then sweep the configuration under bursty input and
// response stalls.
// ----------------------------------------------------------------------------
module uart_transmitter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import utx_pkg::*;

   localparam int          CLOCK_PERIOD   = 10;
   localparam int          RESET_CYCLES   = 10;
   localparam int          TOTAL_TICKS    = 1400;
   localparam int          HOLDOFF_CYCLES = 150;
   localparam int          SETTLE_CYCLES  = 20;
   localparam longint      RUN_LIMIT_NS   = 5_000_000;
   localparam int          SCRIPT_LEN     = 39;
   localparam logic [1:0]  PARITY_SPARE   = 2'd3;   // reserved code, folds to none
   localparam logic [19:0] PERIOD_MAX     = 20'hFFFFF;

   // one tick of line output
   typedef struct packed {
      logic line_level;
      logic driver_enable;
      logic busy_res;
      logic accepted;
   } line_tick_type;

   // a tick offered to the block, with a hand-written result where one applies
   typedef struct packed {
      logic          pinned;
      line_tick_type want;
   } offered_tick_type;

   typedef enum logic {
      ROW_TICK,
      ROW_WRITE
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [2:0]   reg_idx;
      logic [31:0]  value;
      logic         req;
      logic [7:0]   data;
      logic         pinned;
      line_tick_type want;     // {line_level, driver_enable, busy_res, accepted}
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   utx_req_if req_ch ();
   utx_rsp_if rsp_ch ();

   uart_transmitter dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_ch),
      .rsp_if  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor copy of the configuration registers (raw codes, as written)
   // ---------------------------------------------------------------------------
   logic [BIT_PERIOD_W-1:0] cfg_period    = BIT_PERIOD_RESET;
   logic [DATA_BITS_W-1:0]  cfg_data_bits = DATA_BITS_RESET;
   logic [1:0]              cfg_parity    = PARITY_NONE;
   logic [1:0]              cfg_stop      = STOP_BITS_RESET;
   logic                    cfg_invert    = 1'b0;
   logic                    cfg_drive_en  = 1'b0;

   // Predictor copy of the frame engine
   phase_type               tx_phase  = PH_IDLE;
   logic [BIT_PERIOD_W-1:0] tx_ticks  = '0;
   logic [2:0]              tx_bit    = '0;
   logic [7:0]              tx_shift  = '0;
   logic                    tx_parity = 1'b0;
   logic [1:0]              tx_stop   = '0;

   offered_tick_type offered_ticks [$];   // driven, not yet transferred
   line_tick_type    awaited_lines [$];   // transferred, result not yet seen

   int unsigned failures        = 0;
   int unsigned ticks_sent      = 0;
   int unsigned burst_left      = 0;
   logic        gaps_on         = 1'b1;
   int unsigned holdoffs_asked  = 0;
   int unsigned holdoffs_served = 0;
   int unsigned holdoff_left    = 0;
   int unsigned pattern_age     = 0;
   logic [31:0] stall_pattern   = '1;

   // ---------------------------------------------------------------------------
   // Scripted opening. Rows with pinned = 1 carry a result read straight off
   // the frame format; the others are left to the predictor.
   // ---------------------------------------------------------------------------
   script_row_type script_rows [SCRIPT_LEN] = '{
      // idle line rests at mark after reset
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'hFF, 1'b1, 4'b1000},
      // request taken: start bit on the request tick itself
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b1, 8'h00, 1'b1, 4'b0011},
      // request while busy is dropped
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b1, 8'hFF, 1'b1, 4'b0010},
      // period zero acts as one, and the start bit is already past it
      '{ROW_WRITE, REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_WRITE, REG_DATA_BITS,    32'd5, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_WRITE, REG_PARITY_MODE,  32'(PARITY_EVEN), 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_WRITE, REG_STOP_BITS,    32'd2, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_WRITE, REG_INVERT_LINE,  32'd1, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_WRITE, REG_DRIVE_ENABLE, 32'd1, 1'b0, 8'h00, 1'b0, 4'b0000},
      // last start tick, inverted line, driver enabled
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b1, 4'b1110},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b1, 8'h55, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      // request on the tick after the last stop tick: back-to-back frame
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b1, 8'hFF, 1'b1, 4'b1111},
      // out-of-range codes: 15 data bits acts as 8, spare parity as none, 3 stops as 2
      '{ROW_WRITE, REG_DATA_BITS,    32'd15, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_WRITE, REG_PARITY_MODE,  32'(PARITY_SPARE), 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_WRITE, REG_STOP_BITS,    32'd3, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      // zero stop bits acts as one; longest period leaves a frame in flight
      '{ROW_WRITE, REG_STOP_BITS,    32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_WRITE, REG_BIT_PERIOD,   32'(PERIOD_MAX), 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_WRITE, REG_PARITY_MODE,  32'(PARITY_ODD), 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_WRITE, REG_INVERT_LINE,  32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_WRITE, REG_DRIVE_ENABLE, 32'd0, 1'b0, 8'h00, 1'b0, 4'b0000},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b1, 8'hA5, 1'b1, 4'b0011},
      '{ROW_TICK,  REG_BIT_PERIOD,   32'd0, 1'b0, 8'h00, 1'b0, 4'b0000}
   };

   // ---------------------------------------------------------------------------
   // Frame predictor: advance the engine by one tick, return the line outputs.
   // Register changes take effect at once; a count at or past a new, smaller
   // limit closes its bit at the end of the tick.
   // ---------------------------------------------------------------------------
   function automatic line_tick_type serialize_tick(input logic req, input logic [7:0] data);
      line_tick_type           out;
      logic [BIT_PERIOD_W-1:0] period;
      int                      nbits;
      int                      nstop;
      logic                    parity_used;

      out         = '{line_level: 1'b1, driver_enable: 1'b0, busy_res: 1'b0, accepted: 1'b0};
      period      = (cfg_period == '0) ? BIT_PERIOD_W'(1) : cfg_period;
      nbits       = (cfg_data_bits >= DATA_BITS_MIN && cfg_data_bits <= DATA_BITS_MAX)
                    ? int'(cfg_data_bits) : int'(DATA_BITS_MAX);
      nstop       = (cfg_stop == 2'd0) ? 1 : (cfg_stop > 2'd2) ? 2 : int'(cfg_stop);
      parity_used = (cfg_parity == PARITY_EVEN) || (cfg_parity == PARITY_ODD);

      // latch the byte only from idle
      if (tx_phase == PH_IDLE && req) begin
         tx_phase     = PH_START;
         tx_ticks     = '0;
         tx_bit       = '0;
         tx_stop      = '0;
         tx_shift     = data;
         tx_parity    = 1'b0;
         out.accepted = 1'b1;
      end

      if (tx_phase != PH_IDLE) begin
         out.busy_res = 1'b1;
         case (tx_phase)
            PH_START:  out.line_level = 1'b0;
            PH_DATA:   out.line_level = tx_shift[0];
            PH_PARITY: out.line_level = tx_parity ^ (cfg_parity == PARITY_ODD);
            default:   out.line_level = 1'b1;
         endcase
         tx_ticks = tx_ticks + 1'b1;
         if (tx_ticks >= period || tx_ticks == '0) begin
            tx_ticks = '0;
            case (tx_phase)
               PH_START: begin
                  tx_phase = PH_DATA;
                  tx_bit   = '0;
               end
               PH_DATA: begin
                  tx_parity = tx_parity ^ tx_shift[0];
                  tx_shift  = tx_shift >> 1;
                  if (int'(tx_bit) + 1 >= nbits) begin
                     tx_bit = '0;
                     if (parity_used) begin
                        tx_phase = PH_PARITY;
                     end else begin
                        tx_phase = PH_STOP;
                        tx_stop  = '0;
                     end
                  end else begin
                     tx_bit = tx_bit + 1'b1;
                  end
               end
               PH_PARITY: begin
                  tx_phase = PH_STOP;
                  tx_stop  = '0;
               end
               PH_STOP: begin
                  if (int'(tx_stop) + 1 >= nstop) begin
                     tx_phase = PH_IDLE;
                     tx_stop  = '0;
                  end else begin
                     tx_stop = tx_stop + 1'b1;
                  end
               end
               default: tx_phase = PH_IDLE;
            endcase
         end
      end

      out.line_level    = out.line_level ^ cfg_invert;
      out.driver_enable = cfg_drive_en & out.busy_res;
      return out;
   endfunction

   task automatic check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         failures++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Monitor: predict on every request transfer, check on every response
   // transfer. Both are sampled at the same edge the block sees them.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      line_tick_type    predicted;
      line_tick_type    got;
      line_tick_type    want;
      offered_tick_type offer;

      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            predicted = serialize_tick(req_ch.send_request, req_ch.send_byte);
            offer     = offered_ticks.pop_front();
            awaited_lines.push_back(offer.pinned ? offer.want : predicted);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.line_level, rsp_ch.driver_enable, rsp_ch.busy_res, rsp_ch.accepted};
            if (awaited_lines.size() == 0) begin
               $error("response transfer with no tick outstanding");
               failures++;
            end else begin
               want = awaited_lines.pop_front();
               check_field("line_level",    want.line_level,    got.line_level);
               check_field("driver_enable", want.driver_enable, got.driver_enable);
               check_field("busy_res",      want.busy_res,      got.busy_res);
               check_field("accepted",      want.accepted,      got.accepted);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response side: stall on a rotating pattern that is refreshed now and then
   // (all-ready stretches included); serve long hold-offs when asked.
   // ---------------------------------------------------------------------------
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_left == 0 && holdoffs_served < holdoffs_asked) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoffs_served++;
         end
         if (holdoff_left != 0) begin
            rsp_ch.ready <= 1'b0;
            holdoff_left--;
         end else begin
            if (pattern_age == 0) begin
               pattern_age = $urandom_range(64, 400);
               case ($urandom_range(0, 3))
                  0:       stall_pattern = '1;
                  1:       stall_pattern = $urandom | $urandom;
                  2:       stall_pattern = $urandom | 32'h1;
                  default: stall_pattern = ($urandom & $urandom) | 32'h1;
               endcase
            end
            pattern_age--;
            rsp_ch.ready  <= stall_pattern[0];
            stall_pattern  = {stall_pattern[0], stall_pattern[31:1]};
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Request side and register port
   // ---------------------------------------------------------------------------

   // Offer one tick; hold it until transferred. Gaps fall between bursts.
   task automatic offer_tick(input logic req, input logic [7:0] data,
                             input logic pinned, input line_tick_type want);
      if (gaps_on && burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      offered_ticks.push_back('{pinned, want});
      req_ch.valid        <= 1'b1;
      req_ch.send_request <= req;
      req_ch.send_byte    <= data;
      do @(posedge clock); while (!req_ch.ready);
      if (burst_left != 0) burst_left--;
      ticks_sent++;
   endtask

   // Drop valid and wait until every outstanding tick has its result.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (offered_ticks.size() != 0 || awaited_lines.size() != 0) @(posedge clock);
   endtask

   // Setup then access phase, then back to idle; mirror the write into the
   // predictor on the edge where the block takes it.
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_BIT_PERIOD:   cfg_period    = value[BIT_PERIOD_W-1:0];
         REG_DATA_BITS:    cfg_data_bits = value[DATA_BITS_W-1:0];
         REG_PARITY_MODE:  cfg_parity    = value[1:0];
         REG_STOP_BITS:    cfg_stop      = value[1:0];
         REG_INVERT_LINE:  cfg_invert    = value[0];
         REG_DRIVE_ENABLE: cfg_drive_en  = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned phase_no;
      int unsigned phase_len;
      int unsigned req_pct;
      logic        long_period;
      logic [31:0] period_value;

      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.send_request = 1'b0;
      req_ch.send_byte    = '0;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // scripted opening: registers only change once the pipe is empty
      foreach (script_rows[i]) begin
         if (script_rows[i].kind == ROW_WRITE) begin
            drain_results();
            write_reg(script_rows[i].reg_idx, script_rows[i].value);
         end else begin
            offer_tick(script_rows[i].req, script_rows[i].data,
                       script_rows[i].pinned, script_rows[i].want);
         end
      end

      // random phases: new settings each phase, mostly short bit periods so
      // that many frames complete; now and then the longest period
      phase_no = 0;
      while (ticks_sent < TOTAL_TICKS) begin
         drain_results();
         long_period = ($urandom_range(0, 11) == 0);
         case ($urandom_range(0, 9))
            0:       period_value = 32'd0;
            1:       period_value = $urandom_range(4, 12);
            default: period_value = $urandom_range(1, 3);
         endcase
         if (long_period) period_value = 32'(PERIOD_MAX);
         write_reg(REG_BIT_PERIOD, period_value);
         write_reg(REG_DATA_BITS, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                              : $urandom_range(5, 8));
         write_reg(REG_PARITY_MODE, $urandom_range(0, 3));
         write_reg(REG_STOP_BITS, $urandom_range(0, 3));
         write_reg(REG_INVERT_LINE, $urandom_range(0, 1));
         write_reg(REG_DRIVE_ENABLE, $urandom_range(0, 1));

         phase_len = long_period ? $urandom_range(10, 30) : $urandom_range(40, 160);
         case ($urandom_range(0, 2))
            0:       req_pct = 5;
            1:       req_pct = 35;
            default: req_pct = 100;   // request every tick: back-to-back frames
         endcase
         gaps_on = ($urandom_range(0, 3) != 0);

         // keep offering while the response side holds off, so the queue
         // fills and the request side stalls
         if (phase_no % 6 == 2) begin
            gaps_on = 1'b0;
            holdoffs_asked++;
         end

         repeat (phase_len) begin
            offer_tick($urandom_range(0, 99) < req_pct, 8'($urandom_range(0, 255)),
                       1'b0, '0);
         end
         phase_no++;
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // hard stop if the run hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/utx_pkg.sv
design/utx_channels.sv
design/utx_csr.sv
design/utx_front.sv
design/utx_fifo.sv
design/utx_back.sv
design/uart_transmitter.sv
design/utx_checker.sv
bench/uart_transmitter_test.sv
